FILE: rtl/luls_pkg.sv
// ----------------------------------------------------------------------------
// luls_pkg
// Types, codes and helpers shared by the LU linear system solver.
// ----------------------------------------------------------------------------
`default_nettype none

package luls_pkg;

  localparam logic [1:0] KIND_MATRIX = 2'd0;
  localparam logic [1:0] KIND_RHS    = 2'd1;
  localparam logic [1:0] KIND_SOLVE  = 2'd2;

  localparam logic [3:0] SIZE_RESET = 4'd8;

  typedef struct packed {
    logic        [1:0]  kind;
    logic        [2:0]  row;
    logic        [2:0]  col;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic        [2:0]  index;
    logic signed [31:0] solution;
    logic               singular;
    logic               last;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_PIV_RD,
    S_PIV_CHK,
    S_DIV_RD,
    S_DIV_GO,
    S_DIV_WAIT,
    S_UPD_L,
    S_UPD_U,
    S_UPD_W,
    S_UPD_MUL,
    S_UPD_WR,
    S_FWD_ROW,
    S_FACC_RD,
    S_FACC_MUL,
    S_FACC_ADD,
    S_FWD_B,
    S_FWD_SUB,
    S_FWD_GO,
    S_FWD_WAIT,
    S_BWD_ROW,
    S_BACC_RD,
    S_BACC_MUL,
    S_BACC_ADD,
    S_BWD_Y,
    S_BWD_WR,
    S_EMIT_RD,
    S_EMIT_LD
  } state_t;

  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    logic [31:0] r;
    if (v > 66'sh0_7FFF_FFFF) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -66'sh0_8000_0000) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/luls_div.sv
// ----------------------------------------------------------------------------
// luls_div
// Restoring fixed point divider, one quotient bit per cycle, saturated result.
// ----------------------------------------------------------------------------
`default_nettype none

module luls_div #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] num,
  input  wire logic [31:0] den,
  output logic             done,
  output logic [31:0]      quo
);

  localparam int NW = 32 + FRAC_BITS;
  localparam int NCW = $clog2(NW + 1);
  localparam logic [NW-1:0] LIM_NEG = NW'(64'h8000_0000);
  localparam logic [NW-1:0] LIM_POS = NW'(64'h7FFF_FFFF);

  logic            busy;
  logic            fin;
  logic [NCW-1:0]  cnt;
  logic [31:0]     rem;
  logic [NW-1:0]   qs;
  logic [31:0]     dmag;
  logic            neg;
  logic [31:0]     nmag;
  logic [32:0]     rem_sh;
  logic            ge;

  assign nmag   = num[31] ? (~num + 32'd1) : num;
  assign rem_sh = {rem, qs[NW-1]};
  assign ge     = rem_sh >= {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= NCW'(NW);
      end else if (busy) begin
        cnt <= cnt - NCW'(1);
        if (cnt == NCW'(1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qs   <= {nmag, {FRAC_BITS{1'b0}}};
      rem  <= 32'd0;
      dmag <= den[31] ? (~den + 32'd1) : den;
      neg  <= num[31] ^ den[31];
    end else if (busy) begin
      rem <= ge ? 32'(rem_sh - {1'b0, dmag}) : rem_sh[31:0];
      qs  <= {qs[NW-2:0], ge};
    end else if (fin) begin
      if (neg) begin
        quo <= (qs > LIM_NEG) ? 32'h8000_0000 : (~qs[31:0] + 32'd1);
      end else begin
        quo <= (qs > LIM_POS) ? 32'h7FFF_FFFF : qs[31:0];
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lu_linear_system_solver.sv
// ----------------------------------------------------------------------------
// lu_linear_system_solver
// Crout LU solve of an N by N fixed point system on one multiplier and one
// bit-serial divider, with matrix and vectors held in local memories.
// ----------------------------------------------------------------------------
// loads: taken while idle, next item accepted in the following cycle
// solve: multiply-adds plus N*(N+1)/2 divides, run one at a time on the
//   shared multiplier and divider
// results: N items in index order, held back while a stalled item waits; in_stall
//   stays high until the last result has gone into the output register
// reset: synchronous; size_in_use returns to 8, memories keep their contents
`default_nettype none

module lu_linear_system_solver #(
  parameter int MAX_N     = 8,
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire luls_pkg::in_item_t in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output luls_pkg::out_item_t     out_item,
  input  wire logic               wr_en,
  input  wire logic [3:0]         wr_data
);

  localparam int IW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int CW = $clog2(MAX_N + 1);
  localparam int AW = (MAX_N > 1) ? $clog2(MAX_N * MAX_N) : 1;
  localparam logic signed [64:0] HALF = 65'sd1 <<< (FRAC_BITS - 1);

  function automatic logic [AW-1:0] maddr(input logic [CW-1:0] r, input logic [CW-1:0] c);
    return AW'(32'(r) * MAX_N + 32'(c));
  endfunction

  luls_pkg::state_t state, state_next;

  logic [3:0]         size_in_use;
  logic [CW-1:0]      n, i, j, k;
  logic               sing;
  logic [31:0]        piv, opa, opb, opw;
  logic signed [63:0] prod;
  logic signed [63:0] acc;
  logic signed [64:0] rnd;
  logic [CW-1:0]      n_eff;
  logic               in_acc;

  logic [31:0]   mat_mem [MAX_N * MAX_N];
  logic [31:0]   u_mem   [MAX_N * MAX_N];
  logic [31:0]   rhs_mem [MAX_N];
  logic [31:0]   yx_mem  [MAX_N];
  logic [AW-1:0] mat_ra, mat_wa, u_ra, u_wa;
  logic [IW-1:0] rhs_ra, rhs_wa, yx_ra, yx_wa;
  logic [31:0]   mat_rd, u_rd, rhs_rd, yx_rd, mat_wd, rhs_wd, yx_wd;
  logic          mat_we, u_we, rhs_we, yx_we;

  logic          div_start, div_done;
  logic [31:0]   div_num, div_den, div_quo;

  luls_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign in_stall = (state != luls_pkg::S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign rnd      = ($signed({prod[63], prod}) + HALF) >>> FRAC_BITS;

  always_comb begin
    if (size_in_use == 4'd0) begin
      n_eff = CW'(1);
    end else if (32'(size_in_use) > MAX_N) begin
      n_eff = CW'(MAX_N);
    end else begin
      n_eff = CW'(size_in_use);
    end
  end

  always_ff @(posedge clk) begin
    if (mat_we) begin
      mat_mem[mat_wa] <= mat_wd;
    end
    mat_rd <= mat_mem[mat_ra];
  end

  // upper factor, kept apart from the matrix memory that holds the lower factor
  always_ff @(posedge clk) begin
    if (u_we) begin
      u_mem[u_wa] <= div_quo;
    end
    u_rd <= u_mem[u_ra];
  end

  always_ff @(posedge clk) begin
    if (rhs_we) begin
      rhs_mem[rhs_wa] <= rhs_wd;
    end
    rhs_rd <= rhs_mem[rhs_ra];
  end

  always_ff @(posedge clk) begin
    if (yx_we) begin
      yx_mem[yx_wa] <= yx_wd;
    end
    yx_rd <= yx_mem[yx_ra];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      luls_pkg::S_IDLE: begin
        if (in_acc && in_item.kind == luls_pkg::KIND_SOLVE) state_next = luls_pkg::S_PIV_RD;
      end
      luls_pkg::S_PIV_RD:  state_next = luls_pkg::S_PIV_CHK;
      luls_pkg::S_PIV_CHK: begin
        if (mat_rd == 32'd0)  state_next = luls_pkg::S_EMIT_RD;
        else if (i + CW'(1) == n) state_next = luls_pkg::S_FWD_ROW;
        else                  state_next = luls_pkg::S_DIV_RD;
      end
      luls_pkg::S_DIV_RD:   state_next = luls_pkg::S_DIV_GO;
      luls_pkg::S_DIV_GO:   state_next = luls_pkg::S_DIV_WAIT;
      luls_pkg::S_DIV_WAIT: begin
        if (div_done) state_next = (j + CW'(1) < n) ? luls_pkg::S_DIV_RD : luls_pkg::S_UPD_L;
      end
      luls_pkg::S_UPD_L:   state_next = luls_pkg::S_UPD_U;
      luls_pkg::S_UPD_U:   state_next = luls_pkg::S_UPD_W;
      luls_pkg::S_UPD_W:   state_next = luls_pkg::S_UPD_MUL;
      luls_pkg::S_UPD_MUL: state_next = luls_pkg::S_UPD_WR;
      luls_pkg::S_UPD_WR: begin
        if (k + CW'(1) == n && j + CW'(1) == n) state_next = luls_pkg::S_PIV_RD;
        else                                     state_next = luls_pkg::S_UPD_L;
      end
      luls_pkg::S_FWD_ROW:  state_next = (i == CW'(0)) ? luls_pkg::S_FWD_B : luls_pkg::S_FACC_RD;
      luls_pkg::S_FACC_RD:  state_next = luls_pkg::S_FACC_MUL;
      luls_pkg::S_FACC_MUL: state_next = luls_pkg::S_FACC_ADD;
      luls_pkg::S_FACC_ADD: state_next = (k + CW'(1) < i) ? luls_pkg::S_FACC_RD : luls_pkg::S_FWD_B;
      luls_pkg::S_FWD_B:    state_next = luls_pkg::S_FWD_SUB;
      luls_pkg::S_FWD_SUB:  state_next = luls_pkg::S_FWD_GO;
      luls_pkg::S_FWD_GO:   state_next = luls_pkg::S_FWD_WAIT;
      luls_pkg::S_FWD_WAIT: begin
        if (div_done) state_next = (i + CW'(1) < n) ? luls_pkg::S_FWD_ROW : luls_pkg::S_BWD_ROW;
      end
      luls_pkg::S_BWD_ROW:  state_next = (i + CW'(1) < n) ? luls_pkg::S_BACC_RD : luls_pkg::S_BWD_Y;
      luls_pkg::S_BACC_RD:  state_next = luls_pkg::S_BACC_MUL;
      luls_pkg::S_BACC_MUL: state_next = luls_pkg::S_BACC_ADD;
      luls_pkg::S_BACC_ADD: state_next = (j + CW'(1) < n) ? luls_pkg::S_BACC_RD : luls_pkg::S_BWD_Y;
      luls_pkg::S_BWD_Y:    state_next = luls_pkg::S_BWD_WR;
      luls_pkg::S_BWD_WR:   state_next = (i == CW'(0)) ? luls_pkg::S_EMIT_RD : luls_pkg::S_BWD_ROW;
      luls_pkg::S_EMIT_RD:  state_next = luls_pkg::S_EMIT_LD;
      luls_pkg::S_EMIT_LD: begin
        if (!out_valid || !out_stall) begin
          state_next = (i + CW'(1) == n) ? luls_pkg::S_IDLE : luls_pkg::S_EMIT_RD;
        end
      end
      default: state_next = luls_pkg::S_IDLE;
    endcase
  end

  // memory and divider controls
  always_comb begin
    mat_ra    = '0;
    mat_we    = 1'b0;
    mat_wa    = '0;
    mat_wd    = '0;
    u_ra      = '0;
    u_we      = 1'b0;
    u_wa      = maddr(i, j);
    rhs_ra    = i[IW-1:0];
    rhs_we    = 1'b0;
    rhs_wa    = IW'(in_item.row);
    rhs_wd    = in_item.value;
    yx_ra     = i[IW-1:0];
    yx_we     = 1'b0;
    yx_wa     = i[IW-1:0];
    yx_wd     = div_quo;
    div_start = 1'b0;
    div_num   = opa;
    div_den   = opb;
    unique case (state)
      luls_pkg::S_IDLE: begin
        mat_wa = AW'(32'(in_item.row) * MAX_N + 32'(in_item.col));
        mat_wd = in_item.value;
        if (in_acc && in_item.kind == luls_pkg::KIND_MATRIX &&
            32'(in_item.row) < MAX_N && 32'(in_item.col) < MAX_N) mat_we = 1'b1;
        if (in_acc && in_item.kind == luls_pkg::KIND_RHS && 32'(in_item.row) < MAX_N) begin
          rhs_we = 1'b1;
        end
      end
      luls_pkg::S_PIV_RD: mat_ra = maddr(i, i);
      luls_pkg::S_DIV_RD: mat_ra = maddr(i, j);
      luls_pkg::S_DIV_GO: begin
        div_start = 1'b1;
        div_num   = mat_rd;
        div_den   = piv;
      end
      luls_pkg::S_DIV_WAIT: u_we = div_done;
      luls_pkg::S_UPD_L: mat_ra = maddr(j, i);
      luls_pkg::S_UPD_U: u_ra = maddr(i, k);
      luls_pkg::S_UPD_W: mat_ra = maddr(j, k);
      luls_pkg::S_UPD_WR: begin
        mat_we = 1'b1;
        mat_wa = maddr(j, k);
        mat_wd = luls_pkg::sat32($signed({{34{opw[31]}}, opw}) - $signed({rnd[64], rnd}));
      end
      luls_pkg::S_FACC_RD: begin
        mat_ra = maddr(i, k);
        yx_ra  = k[IW-1:0];
      end
      luls_pkg::S_FWD_B: mat_ra = maddr(i, i);
      luls_pkg::S_FWD_GO: div_start = 1'b1;
      luls_pkg::S_FWD_WAIT: yx_we = div_done;
      luls_pkg::S_BACC_RD: begin
        u_ra  = maddr(i, j);
        yx_ra = j[IW-1:0];
      end
      luls_pkg::S_BWD_WR: begin
        yx_we = 1'b1;
        yx_wd = luls_pkg::sat32($signed({{34{yx_rd[31]}}, yx_rd}) -
                                $signed({{2{acc[63]}}, acc}));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= luls_pkg::S_IDLE;
      size_in_use <= luls_pkg::SIZE_RESET;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (wr_en) size_in_use <= wr_data;
      if (state == luls_pkg::S_EMIT_LD && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // counters and datapath
  always_ff @(posedge clk) begin
    case (state)
      luls_pkg::S_IDLE: begin
        n    <= n_eff;
        i    <= '0;
        sing <= 1'b0;
      end
      luls_pkg::S_PIV_CHK: begin
        piv <= mat_rd;
        j   <= i + CW'(1);
        if (mat_rd == 32'd0) begin
          sing <= 1'b1;
          i    <= '0;
        end else if (i + CW'(1) == n) begin
          i <= '0;
        end
      end
      luls_pkg::S_DIV_WAIT: begin
        if (div_done) begin
          if (j + CW'(1) < n) begin
            j <= j + CW'(1);
          end else begin
            j <= i + CW'(1);
            k <= i + CW'(1);
          end
        end
      end
      luls_pkg::S_UPD_U: opa <= mat_rd;
      luls_pkg::S_UPD_W: opb <= u_rd;
      luls_pkg::S_UPD_MUL: begin
        opw  <= mat_rd;
        prod <= $signed(opa) * $signed(opb);
      end
      luls_pkg::S_UPD_WR: begin
        if (k + CW'(1) < n) begin
          k <= k + CW'(1);
        end else begin
          k <= i + CW'(1);
          if (j + CW'(1) < n) j <= j + CW'(1);
          else                i <= i + CW'(1);
        end
      end
      luls_pkg::S_FWD_ROW: begin
        acc <= '0;
        k   <= '0;
      end
      luls_pkg::S_FACC_MUL: prod <= $signed(mat_rd) * $signed(yx_rd);
      luls_pkg::S_BACC_MUL: prod <= $signed(u_rd) * $signed(yx_rd);
      luls_pkg::S_FACC_ADD: begin
        acc <= acc + rnd[63:0];
        k   <= k + CW'(1);
      end
      luls_pkg::S_FWD_SUB: begin
        opa <= luls_pkg::sat32($signed({{34{rhs_rd[31]}}, rhs_rd}) -
                               $signed({{2{acc[63]}}, acc}));
        opb <= mat_rd;
      end
      luls_pkg::S_FWD_WAIT: begin
        if (div_done) i <= (i + CW'(1) < n) ? i + CW'(1) : n - CW'(1);
      end
      luls_pkg::S_BWD_ROW: begin
        acc <= '0;
        j   <= i + CW'(1);
      end
      luls_pkg::S_BACC_ADD: begin
        acc <= acc + rnd[63:0];
        j   <= j + CW'(1);
      end
      luls_pkg::S_BWD_WR: begin
        if (i != CW'(0)) i <= i - CW'(1);
      end
      luls_pkg::S_EMIT_LD: begin
        if (!out_valid || !out_stall) begin
          out_item.index    <= 3'(i);
          out_item.solution <= sing ? 32'sd0 : $signed(yx_rd);
          out_item.singular <= sing;
          out_item.last     <= (i + CW'(1) == n);
          i                 <= i + CW'(1);
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/luls_checker.sv
// ----------------------------------------------------------------------------
// luls_checker
// Port level checks for the LU linear system solver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module luls_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire luls_pkg::in_item_t  in_item,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire luls_pkg::out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result item changed");

  a_busy_mid_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.last |-> in_stall)
    else $error("input taken before run finished");

  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.singular |-> out_item.solution == 32'sd0)
    else $error("singular result not zero");

  a_solve_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_item.kind == luls_pkg::KIND_SOLVE |=> in_stall)
    else $error("solve item did not make block busy");

endmodule

bind lu_linear_system_solver luls_checker u_luls_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

`default_nettype wire

FILE: test/lu_linear_system_solver_tb.sv
// ----------------------------------------------------------------------------
// lu_linear_system_solver_tb
// Loads matrices and right-hand vectors, starts solves and checks every
// solution item against a Crout LU predictor kept in the testbench, under
// random idling on both channels and several system sizes.
// ----------------------------------------------------------------------------
`default_nettype none

module lu_linear_system_solver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          DIM         = 8;
  localparam int          FRAC        = 16;
  localparam logic [1:0]  KIND_UNUSED = 2'd3;
  localparam int          ONE         = 65536;
  localparam int          LIMIT       = 1500000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  luls_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  logic                out_stall = 1'b1;
  luls_pkg::out_item_t out_item;
  logic                wr_en = 1'b0;
  logic [3:0]          wr_data = '0;

  luls_pkg::in_item_t  pending[$];
  luls_pkg::out_item_t solutions_due[$];
  int        send_idle = 0;
  int        recv_idle = 0;
  int        mismatches = 0;
  int        cycles = 0;

  logic [3:0] size_reg = luls_pkg::SIZE_RESET;
  int         a_mat[DIM*DIM];
  int         l_fac[DIM*DIM];
  int         u_fac[DIM*DIM];
  int         b_vec[DIM];
  int         y_vec[DIM];
  int         x_vec[DIM];

  lu_linear_system_solver dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .wr_en(wr_en), .wr_data(wr_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int sat32(longint v);
    int r;
    if (v > 64'sd2147483647) r = 32'h7FFF_FFFF;
    else if (v < -64'sd2147483648) r = 32'h8000_0000;
    else r = int'(v);
    return r;
  endfunction

  function automatic longint fx_mul(int a, int b);
    longint v;
    v = longint'(a) * longint'(b) + (longint'(1) <<< (FRAC - 1));
    return v >>> FRAC;
  endfunction

  function automatic int fx_div(int a, int b);
    longint num;
    num = longint'(a) * (longint'(1) <<< FRAC);
    return sat32(num / longint'(b));
  endfunction

  task automatic apply_item(luls_pkg::in_item_t it);
    int                  n;
    bit                  sing;
    longint              acc;
    int                  p;
    luls_pkg::out_item_t r;
    sing = 1'b0;
    case (it.kind)
      luls_pkg::KIND_MATRIX: a_mat[it.row*DIM + it.col] = it.value;
      luls_pkg::KIND_RHS:    b_vec[it.row] = it.value;
      luls_pkg::KIND_SOLVE: begin
        n = (size_reg == 0) ? 1 : (size_reg > DIM) ? DIM : size_reg;
        for (int i = 0; i < n; i++) begin
          p = a_mat[i*DIM + i];
          if (p == 0) begin
            sing = 1'b1;
            break;
          end
          l_fac[i*DIM + i] = p;
          u_fac[i*DIM + i] = ONE;
          for (int j = i + 1; j < n; j++) begin
            l_fac[j*DIM + i] = a_mat[j*DIM + i];
            u_fac[i*DIM + j] = fx_div(a_mat[i*DIM + j], p);
          end
          for (int j = i + 1; j < n; j++)
            for (int k = i + 1; k < n; k++)
              a_mat[j*DIM + k] = sat32(longint'(a_mat[j*DIM + k])
                                       - fx_mul(l_fac[j*DIM + i], u_fac[i*DIM + k]));
        end
        if (!sing) begin
          for (int i = 0; i < n; i++) begin
            acc = 0;
            for (int k = 0; k < i; k++) acc += fx_mul(l_fac[i*DIM + k], y_vec[k]);
            y_vec[i] = fx_div(sat32(longint'(b_vec[i]) - acc), l_fac[i*DIM + i]);
          end
          for (int i = n - 1; i >= 0; i--) begin
            acc = 0;
            for (int j = i + 1; j < n; j++) acc += fx_mul(u_fac[i*DIM + j], x_vec[j]);
            x_vec[i] = sat32(longint'(y_vec[i]) - acc);
          end
        end
        for (int i = 0; i < n; i++) begin
          r.index    = 3'(i);
          r.solution = sing ? 32'sd0 : x_vec[i];
          r.singular = sing;
          r.last     = (i == n - 1);
          solutions_due.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) apply_item(in_item);
      if (!in_valid || !in_stall) begin
        if (pending.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_item  <= pending.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    luls_pkg::out_item_t e;
    if (rst) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
      if (out_valid && !out_stall) begin
        if (solutions_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected item: index %0d solution %0d singular %0b last %0b",
                     out_item.index, out_item.solution, out_item.singular, out_item.last);
        end else begin
          e = solutions_due.pop_front();
          if (out_item.index !== e.index || out_item.solution !== e.solution ||
              out_item.singular !== e.singular || out_item.last !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
                       e.index, e.solution, e.singular, e.last, out_item.index,
                       out_item.solution, out_item.singular, out_item.last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic luls_pkg::in_item_t mk(logic [1:0] k, int r, int c, int v);
    luls_pkg::in_item_t it;
    it.kind  = k;
    it.row   = 3'(r);
    it.col   = 3'(c);
    it.value = v;
    return it;
  endfunction

  task automatic drain();
    @(negedge clk);
    while (pending.size() > 0 || in_valid || solutions_due.size() > 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_size(logic [3:0] s);
    @(posedge clk);
    wr_en   <= 1'b1;
    wr_data <= s;
    size_reg = s;
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic load_system(int n, int m[], int b[]);
    for (int i = 0; i < n*n; i++)
      pending.push_back(mk(luls_pkg::KIND_MATRIX, i / n, i % n, m[i]));
    for (int i = 0; i < n; i++) pending.push_back(mk(luls_pkg::KIND_RHS, i, 0, b[i]));
    pending.push_back(mk(luls_pkg::KIND_SOLVE, $urandom_range(7), $urandom_range(7), $urandom));
  endtask

  task automatic directed_items();
    @(negedge clk);
    load_system(2, '{32'h7FFF_FFFF, 32'h8000_0000, -1, 1}, '{32'h8000_0000, 32'h7FFF_FFFF});
    load_system(2, '{0, ONE, ONE, ONE}, '{ONE, ONE});
    pending.push_back(mk(KIND_UNUSED, 7, 7, 32'hFFFF_FFFF));
    load_system(2, '{ONE, ONE, ONE, ONE}, '{ONE, -ONE});
    pending.push_back(mk(KIND_UNUSED, 0, 0, 0));
  endtask

  task automatic random_solve(int n);
    int ord[];
    int sty;
    int z;
    int v;
    int r;
    int c;
    ord = new[n*n];
    foreach (ord[i]) ord[i] = i;
    ord.shuffle();
    sty = $urandom_range(9);
    z   = $urandom_range(n - 1);
    foreach (ord[i]) begin
      r = ord[i] / n;
      c = ord[i] % n;
      if (sty == 0) v = $urandom;
      else if (r == c && sty == 1 && r == z) v = 0;
      else if (r == c) v = ($urandom_range(1) ? 1 : -1) * int'($urandom_range(2*ONE, 5*ONE));
      else v = int'($urandom_range(0, 2*ONE)) - ONE;
      pending.push_back(mk(luls_pkg::KIND_MATRIX, r, c, v));
      if ($urandom_range(19) == 0)
        pending.push_back(mk(KIND_UNUSED, $urandom_range(7), $urandom_range(7), $urandom));
    end
    for (int i = 0; i < n; i++) begin
      v = (sty == 0) ? int'($urandom) : int'($urandom_range(0, 16*ONE)) - 8*ONE;
      pending.push_back(mk(luls_pkg::KIND_RHS, i, $urandom_range(7), v));
    end
    pending.push_back(mk(luls_pkg::KIND_SOLVE, $urandom_range(7), $urandom_range(7), $urandom));
  endtask

  task automatic random_batch(logic [3:0] s);
    int n;
    int cnt;
    n = (s == 0) ? 1 : (s > DIM) ? DIM : s;
    write_size(s);
    @(negedge clk);
    cnt = 0;
    while (cnt < 12) begin
      random_solve(n);
      cnt += n*n + n + 1;
    end
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 37 : (ph == 1) ? 83 : 0;
      recv_idle = (ph == 0) ? 83 : (ph == 1) ? 37 : 0;
      if (ph == 0) begin
        write_size(4'd2);
        directed_items();
        drain();
        random_batch(4'd8);
      end
      random_batch(4'd1);
      random_batch(4'd0);
      random_batch(4'(2 + ph));
      if (ph == 2) random_batch(4'd15);
    end
    drain();
    if (mismatches == 0 && solutions_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
